// ===== rtl/isc_pkg.sv =====
// Shared types and constants for the insertion sort block with operation counts.
// No dependencies; every other file in rtl/ imports this package.
package isc_pkg;

    // Field widths fixed by the data format
    localparam int VAL_W   = 32;
    localparam int CMP_W   = 11;
    localparam int MOV_W   = 12;
    localparam int TDATA_W = 56;   // value + comparisons + moves, padded to bytes

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [CMP_W-1:0]        cmp_t;
    typedef logic [MOV_W-1:0]        mov_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_LOAD,     // taking input beats, one insertion per cycle
        ST_SETTLE,   // last counts being accumulated
        ST_EMIT      // draining the chain out of cell 0
    } state_t;

    // Control broadcast to every cell
    typedef struct packed {
        logic ins;     // insert the broadcast value
        logic drain;   // shift every entry down by one place
    } cell_ctrl_t;

endpackage

// ===== rtl/isc_cell.sv =====
// One cell of the insertion chain: holds one sorted entry and its valid bit.
// Depends on isc_pkg.
module isc_cell
    import isc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  val_t       new_value,
    input  logic       prev_valid,   // lower neighbor holds an entry
    input  logic       prev_gt,      // lower neighbor moves up on this insert
    input  val_t       prev_value,
    input  logic       next_valid,   // upper neighbor, used while draining
    input  val_t       next_value,
    output logic       valid,
    output logic       gt,
    output val_t       value
);

    logic valid_reg, valid_next;
    val_t value_reg, value_next;

    // Stored entry is strictly greater than the arriving key: it shifts up
    assign gt = valid_reg && (new_value < value_reg);

    // Next entry: take from below, take the key, or shift down on drain
    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.drain) begin
            valid_next = next_valid;
            value_next = next_value;
        end else if (ctrl.ins) begin
            if (prev_gt) begin
                valid_next = 1'b1;
                value_next = prev_value;
            end else if (gt || (!valid_reg && prev_valid)) begin
                valid_next = 1'b1;
                value_next = new_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

// ===== rtl/isc_count.sv =====
// Comparison and move counters: encodes the insert position from the cell
// compare flags, registers it, then accumulates the counts. Depends on isc_pkg.
module isc_count
    import isc_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           ins,
    input  logic                           clear,
    input  logic [MAX_ITEMS-1:0]           gt_vec,
    input  logic [$clog2(MAX_ITEMS+1)-1:0] count,
    output cmp_t                           comparisons,
    output mov_t                           moves
);

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [MAX_ITEMS-1:0] edge_vec;
    logic [IW-1:0]        pos_enc;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        n_reg;
    logic [CW-1:0]        shifts;
    logic                 pend_reg, pend_next;
    cmp_t                 cmp_reg, cmp_next;
    mov_t                 mov_reg, mov_next;

    // Lowest shifting cell marks the insert position (flags are a thermometer)
    assign edge_vec = gt_vec & ~{gt_vec[MAX_ITEMS-2:0], 1'b0};

    always_comb begin
        pos_enc = '0;
        for (int i = 0; i < MAX_ITEMS; i++) begin
            if (edge_vec[i]) begin
                pos_enc = pos_enc | IW'(i);
            end
        end
        pos_next = (|edge_vec) ? CW'(pos_enc) : count;
    end

    // First item of a set costs nothing
    assign pend_next = ins && (count != '0);

    // Shifts = entries above the insert position; one extra compare unless
    // the scan ran off the bottom
    assign shifts = n_reg - pos_reg;

    always_comb begin
        cmp_next = cmp_reg;
        mov_next = mov_reg;
        if (clear) begin
            cmp_next = '0;
            mov_next = '0;
        end else if (pend_reg) begin
            cmp_next = cmp_reg + CMP_W'(shifts) + CMP_W'(pos_reg != '0);
            mov_next = mov_reg + MOV_W'(shifts) + MOV_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            cmp_reg  <= '0;
            mov_reg  <= '0;
        end else begin
            pend_reg <= pend_next;
            cmp_reg  <= cmp_next;
            mov_reg  <= mov_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        n_reg   <= count;
    end

    assign comparisons = cmp_reg;
    assign moves       = mov_reg;

endmodule

// ===== rtl/insertion_sort_with_counts.sv =====
// Top level of the insertion sort block: chain of isc_cell, isc_count and
// the load/emit sequencer. Depends on isc_pkg, isc_cell, isc_count.
//
//  channel | dir | tdata (low bit up)                       | tuser    | tlast
//  s_      | in  | value[31:0]                              | -        | last
//  m_      | out | sorted_value, comparisons, moves, pad    | overflow | final_res
//
// Loading takes one beat per cycle: every cell compares against the new key
// at once and the chain shifts in the same cycle.
// After the beat with tlast, a settle state lets the counter pipeline catch
// up; then one result beat per cycle, while m_tready is high, drains out of
// cell 0 (n beats).
// Input is not ready from the tlast beat until the final result beat is taken.
// Reset clears valid bits, counts and the sequencer; no clearing pass.
// m_tready low holds the current result and stalls the drain.
module insertion_sort_with_counts
    import isc_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VAL_W-1:0]   s_tdata,    // value[31:0]
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,    // sorted_value[31:0], comparisons[42:32],
                                           // moves[54:43], zero[55]
    output logic               m_tuser,    // overflow
    output logic               m_tlast
);

    localparam int CW = $clog2(MAX_ITEMS + 1);

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic                 s_beat, m_beat, full, clear;
    cell_ctrl_t           ctrl;
    logic [MAX_ITEMS-1:0] valid_vec;
    logic [MAX_ITEMS-1:0] gt_vec;
    val_t                 value_arr [MAX_ITEMS];
    cmp_t                 comparisons;
    mov_t                 moves;

    assign s_beat = s_tvalid && s_tready;
    assign m_beat = m_tvalid && m_tready;
    assign full   = (count_reg == CW'(MAX_ITEMS));
    assign clear  = m_beat && m_tlast;

    assign ctrl = '{ins: s_beat && !full, drain: m_beat};

    // Sequencer: next state and handshake outputs
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready && m_tlast) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Item count and overflow flag
    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (clear) begin
            count_next = '0;
            ovf_next   = 1'b0;
        end else if (s_beat) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Insertion chain; cell 0 holds the smallest entry
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        logic pv, pg, nv;
        val_t pval, nval;
        if (i == 0) begin : g_bottom
            assign pv   = 1'b1;
            assign pg   = 1'b0;
            assign pval = value_arr[0];
        end else begin : g_lower
            assign pv   = valid_vec[i-1];
            assign pg   = gt_vec[i-1];
            assign pval = value_arr[i-1];
        end
        if (i == MAX_ITEMS - 1) begin : g_top
            assign nv   = 1'b0;
            assign nval = value_arr[i];
        end else begin : g_upper
            assign nv   = valid_vec[i+1];
            assign nval = value_arr[i+1];
        end
        isc_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .new_value  (s_tdata),
            .prev_valid (pv),
            .prev_gt    (pg),
            .prev_value (pval),
            .next_valid (nv),
            .next_value (nval),
            .valid      (valid_vec[i]),
            .gt         (gt_vec[i]),
            .value      (value_arr[i])
        );
    end

    isc_count #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_count (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ins         (ctrl.ins),
        .clear       (clear),
        .gt_vec      (gt_vec),
        .count       (count_reg),
        .comparisons (comparisons),
        .moves       (moves)
    );

    // Result beat straight from the bottom cell
    assign m_tdata = {1'b0, moves, comparisons, value_arr[0]};
    assign m_tuser = ovf_reg;
    assign m_tlast = !valid_vec[1];

    // Valid cells match the item count until the drain starts
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_EMIT) |-> ($countones(valid_vec) == count_reg))
        else $error("cell valid bits disagree with item count");

    // Shifting cells form a contiguous run at the top of the stored prefix
    a_gt_thermo: assert property (@(posedge aclk) disable iff (!aresetn)
        ((gt_vec << 1) & ~gt_vec & valid_vec) == '0)
        else $error("compare flags not monotone, chain out of order");

    // A result beat always comes from an occupied cell
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> valid_vec[0])
        else $error("result shown from an empty cell");

    // The tlast input beat leads to results after the settle state
    a_emit_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && s_tlast) |=> ##1 m_tvalid)
        else $error("run did not start after the final item");

    // End of run empties the chain and reopens the input
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        clear |=> (s_tready && valid_vec == '0 && count_reg == '0))
        else $error("chain not empty after the end of the run");

endmodule

// ===== bench/insertion_sort_with_counts_tb.sv =====
// Self-checking bench for insertion_sort_with_counts: sets of signed keys go in,
// each sorted run with its comparison/move counts and overflow flag is checked.
// Depends on isc_pkg and the RTL top level; no files or arguments are read.
module insertion_sort_with_counts_tb;
    import isc_pkg::*;

    localparam int DEPTH        = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TARGET_ITEMS = 410;
    localparam int DIR_ROWS     = 16;
    localparam int HOLD_CYCLES  = 400;

    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_ASC,
        SHAPE_DESC,
        SHAPE_FLAT,
        SHAPE_FEW
    } set_shape_t;

    // One output beat as the bench expects it
    typedef struct {
        val_t sval;
        logic fin;
        cmp_t cmp;
        mov_t mov;
        logic ovf;
    } sorted_beat_t;

    // Directed stimulus row; typed rows carry their single result beat
    typedef struct {
        val_t         value;
        logic         last;
        logic         typed;
        sorted_beat_t exp;
    } dir_row_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [VAL_W-1:0]   s_tdata;    // value[31:0]
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;    // sorted_value[31:0], comparisons[42:32],
                                    // moves[54:43], zero[55]
    logic               m_tuser;    // overflow
    logic               m_tlast;

    insertion_sort_with_counts #(.MAX_ITEMS(DEPTH)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 10-unit clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Sorted-set tracker: ascending prefix plus the running counts
    val_t         run_vals [DEPTH];
    int           run_len;
    cmp_t         run_cmp;
    mov_t         run_mov;
    logic         run_ovf;
    sorted_beat_t pending_sorted_q [$];

    int errors;
    int beats_in;
    int beats_out;
    int sets_done;
    int overflow_sets;
    int cycle_count;
    dir_row_t dir_rows [DIR_ROWS];

    // Insert one key: scan down from the top while strictly less (stable on ties)
    function automatic void insert_key(val_t v);
        int   pos;
        logic done;
        if (run_len >= DEPTH) begin
            run_ovf = 1'b1;
            return;
        end
        if (run_len == 0) begin
            run_vals[0] = v;
            run_len     = 1;
            return;
        end
        pos  = run_len;
        done = 1'b0;
        while (pos > 0 && !done) begin
            run_cmp = run_cmp + 1'b1;
            if (v < run_vals[pos-1]) begin
                run_vals[pos] = run_vals[pos-1];
                run_mov       = run_mov + 1'b1;
                pos--;
            end else begin
                done = 1'b1;
            end
        end
        run_vals[pos] = v;
        run_mov       = run_mov + 1'b1;
        run_len++;
    endfunction

    // Account for one accepted input beat; on last queue the sorted run and clear
    function automatic void track_beat(val_t v, logic last, logic typed,
                                       sorted_beat_t typed_exp);
        sorted_beat_t b;
        int           k;
        insert_key(v);
        if (last) begin
            if (typed) begin
                pending_sorted_q.push_back(typed_exp);
            end else begin
                for (k = 0; k < run_len; k++) begin
                    b.sval = run_vals[k];
                    b.fin  = (k == run_len - 1);
                    b.cmp  = run_cmp;
                    b.mov  = run_mov;
                    b.ovf  = run_ovf;
                    pending_sorted_q.push_back(b);
                end
            end
            if (run_ovf) overflow_sets++;
            sets_done++;
            run_len = 0;
            run_cmp = '0;
            run_mov = '0;
            run_ovf = 1'b0;
        end
    endfunction

    // Mostly short gaps, a few long ones; none in steady stretches
    function automatic int pick_gap(logic steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one beat from a falling edge, wait for the handshake, then idle for any gap
    task automatic send_beat(val_t v, logic last, logic typed, sorted_beat_t te,
                             int gap);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        track_beat(v, last, typed, te);
        beats_in++;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_set(int n, set_shape_t shape, logic steady);
        sorted_beat_t none;
        val_t         v;
        val_t         few [4];
        int           base;
        int           i;
        none = '{0, 0, 0, 0, 0};
        few  = '{32'sh8000_0000, 32'sh7fff_ffff, 0, $urandom};
        base = $urandom_range(0, 200000) - 100000;
        for (i = 0; i < n; i++) begin
            case (shape)
                SHAPE_ASC:  v = base + i * $urandom_range(0, 500);
                SHAPE_DESC: v = base - i * $urandom_range(1, 500);
                SHAPE_FLAT: v = base;
                SHAPE_FEW:  v = few[$urandom_range(0, 3)];
                default:    v = $urandom;
            endcase
            send_beat(v, i == n - 1, 1'b0, none, pick_gap(steady));
        end
    endtask

    // Result side: random ready pattern, plus one long hold-off while input backs up
    initial begin : ready_driver
        int   r;
        int   len;
        logic level;
        logic held;
        m_tready = 1'b0;
        held     = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (!held && beats_out >= 120) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    level = 1'b1;
                    len   = $urandom_range(1, 4);
                end else if (r < 85) begin
                    level = 1'b0;
                    len   = $urandom_range(1, 3);
                end else if (r < 92) begin
                    level = 1'b0;
                    len   = $urandom_range(10, 40);
                end else begin
                    level = 1'b1;
                    len   = $urandom_range(30, 120);
                end
                m_tready <= level;
                repeat (len) @(negedge aclk);
            end
        end
    end

    // Check every accepted result beat against the oldest expectation
    sorted_beat_t seen_exp;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            beats_out++;
            if (pending_sorted_q.size() == 0) begin
                $error("unexpected result beat: tdata %h tuser %b tlast %b",
                       m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                seen_exp = pending_sorted_q.pop_front();
                if ($signed(m_tdata[31:0]) !== seen_exp.sval) begin
                    $error("sorted_value: expected %0d, got %0d",
                           seen_exp.sval, $signed(m_tdata[31:0]));
                    errors++;
                end
                if (m_tlast !== seen_exp.fin) begin
                    $error("final_res: expected %0d, got %0d", seen_exp.fin, m_tlast);
                    errors++;
                end
                if (m_tdata[42:32] !== seen_exp.cmp) begin
                    $error("comparisons: expected %0d, got %0d",
                           seen_exp.cmp, m_tdata[42:32]);
                    errors++;
                end
                if (m_tdata[54:43] !== seen_exp.mov) begin
                    $error("moves: expected %0d, got %0d", seen_exp.mov, m_tdata[54:43]);
                    errors++;
                end
                if (m_tuser !== seen_exp.ovf) begin
                    $error("overflow: expected %0d, got %0d", seen_exp.ovf, m_tuser);
                    errors++;
                end
                if (m_tdata[55] !== 1'b0) begin
                    $error("pad: expected 0, got %0d", m_tdata[55]);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus: directed table, then random sets
    initial begin : stimulus
        sorted_beat_t none;
        set_shape_t   shape;
        int           set_no;
        int           n;
        int           i;
        logic         steady;

        none     = '{0, 0, 0, 0, 0};
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        run_len  = 0;
        run_cmp  = '0;
        run_mov  = '0;
        run_ovf  = 1'b0;

        // Single-key sets read straight off: no comparison, no move
        dir_rows[0]  = '{32'sh8000_0000, 1, 1, '{32'sh8000_0000, 1, 0, 0, 0}};
        dir_rows[1]  = '{32'sh7fff_ffff, 1, 1, '{32'sh7fff_ffff, 1, 0, 0, 0}};
        dir_rows[2]  = '{0,              1, 1, '{0,              1, 0, 0, 0}};
        dir_rows[3]  = '{-1,             1, 1, '{-1,             1, 0, 0, 0}};
        // Equal keys and mixed order
        dir_rows[4]  = '{5,              0, 0, none};
        dir_rows[5]  = '{3,              0, 0, none};
        dir_rows[6]  = '{3,              0, 0, none};
        dir_rows[7]  = '{9,              0, 0, none};
        dir_rows[8]  = '{-7,             1, 0, none};
        // Already ascending: one compare per key after the first, no shifts
        dir_rows[9]  = '{1,              0, 0, none};
        dir_rows[10] = '{2,              0, 0, none};
        dir_rows[11] = '{3,              1, 0, none};
        // Extremes reversed
        dir_rows[12] = '{32'sh7fff_ffff, 0, 0, none};
        dir_rows[13] = '{32'sh8000_0000, 1, 0, none};
        // Alternating bit patterns
        dir_rows[14] = '{32'sh5555_5555, 0, 0, none};
        dir_rows[15] = '{32'shAAAA_AAAA, 1, 0, none};

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (i = 0; i < DIR_ROWS; i++)
            send_beat(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed,
                      dir_rows[i].exp, pick_gap(1'b0));

        // Mostly small sets; a full set of the descending shape, overflowing sets now and then
        set_no = 0;
        while (beats_in < TARGET_ITEMS) begin
            shape  = set_shape_t'($urandom_range(0, 4));
            steady = ($urandom_range(0, 3) == 0);
            if (set_no == 2) begin
                n     = DEPTH;
                shape = SHAPE_DESC;
            end else if (set_no == 5) begin
                n = DEPTH + 3;
            end else if ($urandom_range(0, 19) == 0) begin
                n = $urandom_range(DEPTH - 4, DEPTH + 6);
            end else begin
                n = $urandom_range(1, 12);
            end
            send_set(n, shape, steady);
            // Let the block drain completely once before going on
            if (set_no == 8) begin
                s_tvalid <= 1'b0;
                while (pending_sorted_q.size() != 0) @(negedge aclk);
            end
            set_no++;
        end

        s_tvalid <= 1'b0;
        while (pending_sorted_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);

        $display("Sent %0d key beats in %0d sets (%0d overflowing), checked %0d sorted beats",
                 beats_in, sets_done, overflow_sets, beats_out);
        if (errors == 0 && pending_sorted_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/isc_pkg.sv
rtl/isc_cell.sv
rtl/isc_count.sv
rtl/insertion_sort_with_counts.sv
bench/insertion_sort_with_counts_tb.sv
